/* rtl/spc_pkg.sv */
package spc_pkg;

  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned COUNT_W     = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned FIRST_PRIME = 2;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture limit, index to first prime, count to zero
    logic clr_wr;   // write a cleared flag at the index, advance index
    logic rst_i;    // index back to first prime
    logic cnt;      // count a prime, start multiple at twice the index
    logic mark_wr;  // write a composite flag at the multiple, step multiple
    logic next_i;   // advance index
  } spc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic i_end;    // index reached the limit
    logic m_end;    // multiple reached the limit
    logic prime;    // flag read back for the index is clear
  } spc_sts_t;

endpackage

/* rtl/sieve_prime_counter.sv */
// channel   signals               transaction taken when
// query     start, limit_i        start high and busy low at a rising edge
// result    done_o, prime_count_o done_o high: one cycle, always taken
//
// A query with saturated limit L (limit_i capped at MAX_N) first clears the flags
// at indices 2 to L-1, then reads and checks the flag of each index from 2 to
// L-1, counts each prime and marks each of its multiples below L in turn;
// the single port of the composite-flag memory keeps these steps serial.
// busy is low again in the cycle that done_o is high. Reset clears the
// controller only; flags from 2 up to the limit minus one are cleared at the start of each query.
module sieve_prime_counter
  import spc_pkg::*;
#(
  parameter int unsigned MAX_N = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               done_o,
  output logic [COUNT_W-1:0] prime_count_o
);

  spc_cmd_t cmd;
  spc_sts_t sts;

  spc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  spc_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk_i   (clk_i),
    .limit_i (limit_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .count_o (prime_count_o)
  );

endmodule

/* rtl/spc_ram.sv */
module spc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spc_dp.sv */
module spc_dp
  import spc_pkg::*;
#(
  parameter int unsigned MAX_N = 65536
) (
  input  logic               clk_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  spc_cmd_t           cmd_i,
  output spc_sts_t           sts_o,
  output logic [COUNT_W-1:0] count_o
);

  localparam int unsigned CW = $clog2(MAX_N + 1);
  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [CW-1:0]      lim_q, i_q;
  logic [CW:0]        m_q;
  logic [COUNT_W-1:0] count_q;
  logic [LW-1:0]      lim_ext;
  logic [CW-1:0]      lim_sat;
  logic [AW-1:0]      ram_addr;
  logic               ram_rdata;

  assign lim_ext = LW'(limit_i);
  assign lim_sat = (lim_ext > LW'(MAX_N)) ? CW'(MAX_N) : lim_ext[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lim_q   <= lim_sat;
      i_q     <= CW'(FIRST_PRIME);
      count_q <= '0;
    end else if (cmd_i.rst_i) begin
      i_q <= CW'(FIRST_PRIME);
    end else if (cmd_i.clr_wr || cmd_i.next_i) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.cnt) begin
      m_q <= {i_q, 1'b0};
      if (count_q != COUNT_MAX) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end else if (cmd_i.mark_wr) begin
      m_q <= m_q + {1'b0, i_q};
    end
  end

  assign ram_addr = cmd_i.mark_wr ? m_q[AW-1:0] : i_q[AW-1:0];

  spc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_N)
  ) u_mark (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.mark_wr),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.mark_wr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.i_end = (i_q >= lim_q);
  assign sts_o.m_end = (m_q >= {1'b0, lim_q});
  assign sts_o.prime = ~ram_rdata;
  assign count_o     = count_q;

endmodule

/* rtl/spc_ctrl.sv */
module spc_ctrl
  import spc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spc_sts_t sts_i,
  output spc_cmd_t cmd_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_CHECK,
    ST_MARK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (sts_i.i_end) begin
          cmd_o.rst_i = 1'b1;
          state_d     = ST_SCAN;
        end else begin
          cmd_o.clr_wr = 1'b1;
        end
      end
      ST_SCAN: begin
        // the flag at the index is read this cycle and checked the next
        if (sts_i.i_end) begin
          busy_d  = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.prime) begin
          cmd_o.cnt = 1'b1;
          state_d   = ST_MARK;
        end else begin
          cmd_o.next_i = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_MARK: begin
        if (sts_i.m_end) begin
          cmd_o.next_i = 1'b1;
          state_d      = ST_SCAN;
        end else begin
          cmd_o.mark_wr = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

/* dv/sieve_prime_counter_tb.sv */
`timescale 1ns / 1ps

module sieve_prime_counter_tb;
  import spc_pkg::*;

  localparam int unsigned MAX_N        = 65536;
  localparam int unsigned N_DIRECTED   = 20;
  localparam int unsigned N_RANDOM     = 100;
  localparam int unsigned STALL_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               typed;  // count below is known by hand
    logic [COUNT_W-1:0] count;
  } query_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [LIMIT_W-1:0] limit_i = '0;
  logic               done_o;
  logic [COUNT_W-1:0] prime_count_o;

  logic [COUNT_W-1:0] pending_counts [$];
  bit                 composite_flags [MAX_N];
  int unsigned        n_errors = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left = 0;

  query_row_t directed_rows [N_DIRECTED] = '{
    '{17'd0,      1'b1, 13'd0},
    '{17'd1,      1'b1, 13'd0},
    '{17'd2,      1'b1, 13'd0},
    '{17'd3,      1'b1, 13'd1},
    '{17'd4,      1'b1, 13'd2},
    '{17'd5,      1'b1, 13'd2},
    '{17'd6,      1'b0, 13'd0},
    '{17'd7,      1'b0, 13'd0},
    '{17'd11,     1'b0, 13'd0},
    '{17'd12,     1'b0, 13'd0},
    '{17'd13,     1'b0, 13'd0},
    '{17'd100,    1'b0, 13'd0},
    '{17'd127,    1'b0, 13'd0},
    '{17'd128,    1'b0, 13'd0},
    '{17'd1000,   1'b0, 13'd0},
    '{17'd65536,  1'b1, 13'd6542},
    // small limit right after a full bitmap: stale flags must be gone
    '{17'd10,     1'b0, 13'd0},
    '{17'd131071, 1'b1, 13'd6542},
    '{17'd2,      1'b1, 13'd0},
    '{17'd1024,   1'b0, 13'd0}
  };

  sieve_prime_counter #(
    .MAX_N(MAX_N)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .limit_i      (limit_i),
    .done_o       (done_o),
    .prime_count_o(prime_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [COUNT_W-1:0] count_primes_below(input logic [LIMIT_W-1:0] lim_in);
    int unsigned lim;
    int unsigned n_primes;
    int unsigned m;
    lim = (lim_in > MAX_N) ? MAX_N : int'(lim_in);
    n_primes = 0;
    for (int unsigned k = 0; k < MAX_N; k++) composite_flags[k] = 1'b0;
    for (int unsigned i = FIRST_PRIME; i < lim; i++) begin
      if (!composite_flags[i]) begin
        n_primes++;
        for (m = 2 * i; m < lim; m += i) composite_flags[m] = 1'b1;
      end
    end
    if (n_primes > COUNT_MAX) return COUNT_MAX;
    return n_primes[COUNT_W-1:0];
  endfunction

  // Keep most limits small: a full bitmap is slow to sieve.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return LIMIT_W'($urandom_range(0, 300));
    if (sel < 95) return LIMIT_W'($urandom_range(301, 2047));
    return LIMIT_W'($urandom_range(2048, 8191));
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic send_query(input logic [LIMIT_W-1:0] lim, input logic [COUNT_W-1:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start   <= 1'b1;
    limit_i <= lim;
    // hold the transaction until the block takes it
    do @(posedge clk_i); while (busy);
    pending_counts.push_back(count);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result prime_count=%0d", prime_count_o));
      end else begin
        if (prime_count_o !== pending_counts[0]) begin
          report_mismatch($sformatf("prime_count got %0d, want %0d",
                                    prime_count_o, pending_counts[0]));
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_counts.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] lim;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      lim = directed_rows[r].limit;
      send_query(lim, directed_rows[r].typed ? directed_rows[r].count
                                             : count_primes_below(lim));
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      lim = pick_limit();
      send_query(lim, count_primes_below(lim));
    end

    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
